/* hw/rtl/blpg_pkg.sv */
// Shared types and constants of the Bresenham line pixel generator.
// Used by blpg_setup and the top level; depends on nothing.
package blpg_pkg;

    // Coordinate width, the widths derived from it, and the other field widths
    localparam int COORD_BITS = 12;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int Z_BITS     = 16;
    localparam int RGB_BITS   = 24;
    localparam int THEME_BITS = 2;

    // Command and theme codes
    localparam logic                  FUNC_LOAD    = 1'b0;
    localparam logic                  FUNC_STEP    = 1'b1;
    localparam logic [THEME_BITS-1:0] THEME_HEIGHT = 2'd1;

    // Fixed colors
    localparam logic [RGB_BITS-1:0] WHITE_RGB     = 24'hffffff;
    localparam logic [RGB_BITS-1:0] BOTH_HIGH_RGB = 24'h9e3d64;
    localparam logic [RGB_BITS-1:0] SLOPED_RGB    = 24'hffb554;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DELTA_BITS-1:0] sdelta_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    // Input item
    typedef struct packed {
        logic                      func;
        coord_t                    x_start;
        coord_t                    y_start;
        coord_t                    x_end;
        coord_t                    y_end;
        logic signed [Z_BITS-1:0]  z_start;
        logic signed [Z_BITS-1:0]  z_end;
        logic [RGB_BITS-1:0]       line_color;
    } in_item_t;

    // Result item
    typedef struct packed {
        coord_t              pixel_x;
        coord_t              pixel_y;
        logic [RGB_BITS-1:0] pixel_color;
        logic                pixel_valid;
        logic                last_pixel;
    } out_item_t;

    // Segment walker state
    typedef struct packed {
        coord_t              cur_x;
        coord_t              cur_y;
        coord_t              stop_coord;
        delta_t              major_delta;
        delta_t              minor_delta;
        err_t                error_term;
        logic                minor_dir;
        logic                steep_flag;
        logic                active_flag;
        logic [RGB_BITS-1:0] seg_color;
    } seg_state_t;

endpackage

/* hw/rtl/bresenham_line_pixel_generator.sv */
// Top level of the Bresenham line pixel generator: segment state, pixel
// stepping and the result register. Depends on blpg_pkg and blpg_setup.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+------------------------------
//  input    | s_valid, s_ready, s_item       | load or step item
//  result   | m_valid, m_ready, m_item       | one pixel item per step
//  config   | cfg_wr_en, cfg_wr_data         | theme_reg, no handshake
//
// One item per clock while s_ready is high: a step reads the segment state,
// registers its pixel and updates the state in the same cycle; a load rewrites
// the state. The result register decouples the sides: s_ready is high whenever
// the result register is empty or being taken.
// Reset (synchronous, active low) clears the segment, theme and result valid registers.
module bresenham_line_pixel_generator import blpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_wr_en,
    input  logic [THEME_BITS-1:0] cfg_wr_data
);

    logic [THEME_BITS-1:0] theme_reg;
    seg_state_t            seg_reg, seg_next, seg_load;
    out_item_t             out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  accept;
    coord_t                maj, mnr, mnr_step;
    sdelta_t               maj_inc;
    err_t                  err_step;
    logic                  last;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    blpg_setup u_setup (
        .item  (s_item),
        .theme (theme_reg),
        .seg   (seg_load)
    );

    // Major and minor axis views of the current pixel
    always_comb begin
        maj      = seg_reg.steep_flag ? seg_reg.cur_y : seg_reg.cur_x;
        mnr      = seg_reg.steep_flag ? seg_reg.cur_x : seg_reg.cur_y;
        maj_inc  = sdelta_t'(maj) + sdelta_t'(1);
        last     = (maj_inc == sdelta_t'(seg_reg.stop_coord));
        mnr_step = seg_reg.minor_dir ? mnr - coord_t'(1) : mnr + coord_t'(1);
        err_step = seg_reg.error_term + err_t'({1'b0, seg_reg.minor_delta, 1'b0});
    end

    // Next state and result for the accepted item
    always_comb begin
        seg_next     = seg_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            unique case (s_item.func)
                FUNC_LOAD: begin
                    seg_next = seg_load;
                end
                FUNC_STEP: begin
                    m_valid_next = 1'b1;
                    out_next     = '0;
                    if (seg_reg.active_flag) begin
                        out_next.pixel_x     = seg_reg.cur_x;
                        out_next.pixel_y     = seg_reg.cur_y;
                        out_next.pixel_color = seg_reg.seg_color;
                        out_next.pixel_valid = 1'b1;
                        out_next.last_pixel  = last;
                        // minor step on a non-negative error
                        if (!seg_reg.error_term[ERR_BITS-1]) begin
                            seg_next.error_term = err_step
                                - err_t'({1'b0, seg_reg.major_delta, 1'b0});
                            if (seg_reg.steep_flag) begin
                                seg_next.cur_x = mnr_step;
                            end else begin
                                seg_next.cur_y = mnr_step;
                            end
                        end else begin
                            seg_next.error_term = err_step;
                        end
                        if (seg_reg.steep_flag) begin
                            seg_next.cur_y = coord_t'(maj_inc);
                        end else begin
                            seg_next.cur_x = coord_t'(maj_inc);
                        end
                        seg_next.active_flag =
                            !(maj_inc >= sdelta_t'(seg_reg.stop_coord));
                    end
                end
                default: begin
                    seg_next = seg_reg;
                end
            endcase
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            theme_reg   <= '0;
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                theme_reg <= cfg_wr_data;
            end
            seg_reg     <= seg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // Checks
    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.pixel_valid) |->
            (m_item.pixel_x == '0 && m_item.pixel_y == '0
             && m_item.pixel_color == '0 && !m_item.last_pixel))
        else $error("empty step result carries nonzero fields");

    a_active_before_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_reg.active_flag |-> (maj < seg_reg.stop_coord))
        else $error("active segment at or past its stop coordinate");

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.func == FUNC_STEP) |=> m_valid_reg)
        else $error("accepted step item produced no result");

    a_last_ends_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.func == FUNC_STEP && seg_reg.active_flag && last)
            |=> !seg_reg.active_flag)
        else $error("segment still active after its last pixel");

endmodule

/* hw/rtl/blpg_setup.sv */
// Segment setup: octant choice, endpoint swap, deltas, initial error, color.
// Purely combinational; depends on blpg_pkg.
module blpg_setup import blpg_pkg::*; (
    input  in_item_t              item,
    input  logic [THEME_BITS-1:0] theme,
    output seg_state_t            seg
);

    coord_t              xa, ya, xb, yb, p0x, p0y, p1x, p1y;
    sdelta_t             dx0, dy0, dx, dy, minor_s;
    delta_t              adx0, ady0, major, minor;
    logic                steep, swap;
    logic [RGB_BITS-1:0] col;

    // Endpoint differences before the swap
    always_comb begin
        xa   = item.x_start;
        ya   = item.y_start;
        xb   = item.x_end;
        yb   = item.y_end;
        dx0  = sdelta_t'(xb) - sdelta_t'(xa);
        dy0  = sdelta_t'(yb) - sdelta_t'(ya);
        adx0 = dx0[DELTA_BITS-1] ? delta_t'(-dx0) : delta_t'(dx0);
        ady0 = dy0[DELTA_BITS-1] ? delta_t'(-dy0) : delta_t'(dy0);
        steep = !(ady0 < adx0);
        swap  = steep ? (ya > yb) : (xa > xb);
    end

    // Order endpoints so the major coordinate increases
    always_comb begin
        p0x = swap ? xb : xa;
        p0y = swap ? yb : ya;
        p1x = swap ? xa : xb;
        p1y = swap ? ya : yb;
        dx  = sdelta_t'(p1x) - sdelta_t'(p0x);
        dy  = sdelta_t'(p1y) - sdelta_t'(p0y);
        major   = steep ? delta_t'(dy) : delta_t'(dx);
        minor_s = steep ? dx : dy;
        minor   = minor_s[DELTA_BITS-1] ? delta_t'(-minor_s) : delta_t'(minor_s);
    end

    // Height-based recolor of white lines
    always_comb begin
        col = item.line_color;
        if (theme == THEME_HEIGHT && item.line_color == WHITE_RGB) begin
            if (item.z_start != '0 && item.z_end != '0) begin
                col = BOTH_HIGH_RGB;
            end else if (item.z_start != item.z_end) begin
                col = SLOPED_RGB;
            end
        end
    end

    // Assemble the new segment state
    always_comb begin
        seg.cur_x       = p0x;
        seg.cur_y       = p0y;
        seg.stop_coord  = steep ? p1y : p1x;
        seg.major_delta = major;
        seg.minor_delta = minor;
        seg.error_term  = err_t'({1'b0, minor, 1'b0}) - err_t'({2'b00, major});
        seg.minor_dir   = minor_s[DELTA_BITS-1];
        seg.steep_flag  = steep;
        seg.active_flag = (major != '0);
        seg.seg_color   = col;
    end

endmodule
